### rtl/sfau_pkg.sv
package sfau_pkg;

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_SQRT = 3'd4
   } op_type;

   localparam int TableDepth = 1024;

   // reciprocal table word: constant (23 bits), gradient (13 bits)
   typedef logic [35:0] recip_rom_type [TableDepth];
   // square root table word: constant (23 bits), gradient (14 bits)
   typedef logic [36:0] sqrt_rom_type [TableDepth];

   // round a positive real to the nearest single-precision value, ties to even
   function automatic real rnd24(input real v);
      real    w;
      real    m;
      real    fr;
      real    p;
      int     e;
      longint t;
      w = v;
      e = 0;
      while (w >= 2.0) begin
         w = w / 2.0;
         e = e + 1;
      end
      while (w < 1.0) begin
         w = w * 2.0;
         e = e - 1;
      end
      m = w * 8388608.0;
      t = longint'(m);
      if (real'(t) > m) t = t - 1;
      fr = m - real'(t);
      if (fr > 0.5 || (fr == 0.5 && t[0])) t = t + 1;
      p = real'(t) / 8388608.0;
      while (e > 0) begin
         p = p * 2.0;
         e = e - 1;
      end
      while (e < 0) begin
         p = p / 2.0;
         e = e + 1;
      end
      return p;
   endfunction

   // 24-bit significand (hidden bit included) of a single-precision value
   function automatic longint mant24(input real v);
      real w;
      w = v;
      while (w >= 2.0) w = w / 2.0;
      while (w < 1.0) w = w * 2.0;
      return longint'(w * 8388608.0);
   endfunction

   // unsigned quotient by shift and subtract, operands below 2^62
   function automatic longint div_q(input longint num, input longint den);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int i = 62; i >= 0; i--) begin
         r = (r << 1) | ((num >> i) & 64'sd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'sd1 << i);
         end
      end
      return q;
   endfunction

   // 1024/d rounded to nearest even, in units of 2^-24
   function automatic longint recip_rn(input longint d);
      longint q;
      longint rm;
      q  = div_q(64'sd1 << 34, d);
      rm = (64'sd1 << 34) - q * d;
      if (2 * rm > d || (2 * rm == d && q[0])) q = q + 1;
      return q;
   endfunction

   // one reciprocal segment: midpoint of the end reciprocals, then tangent terms
   function automatic logic [35:0] recip_entry(input logic [9:0] kl);
      longint k;
      longint s;
      longint x0;
      longint q;
      longint c;
      longint g;
      k  = 64'sd1024 + longint'(kl);
      // sum of the end reciprocals rounded to single precision, then halved
      s  = recip_rn(k) + recip_rn(k + 1);
      x0 = s >> 1;
      if (s[0] && x0[0]) x0 = x0 + 1;
      if (x0 == 64'sd16777216) x0 = 64'sd8388608;
      q  = (x0 * x0 * k) >> 34;
      c  = (2 * x0 - q) & 64'sh0_FFFF_FFFF;
      if (kl == 10'h2 || kl == 10'h3 || kl == 10'h6 || kl == 10'h7 || kl == 10'h9 ||
          kl == 10'ha || kl == 10'he || kl == 10'h19 || kl == 10'h20 || kl == 10'h22)
         c = c + 1;
      c = c & 64'sh7F_FFFF;
      g = ((x0 * x0) >> 35) & 64'sh7F_FFFF;
      return {c[22:0], g[12:0]};
   endfunction

   // one square root segment, index is {exponent parity, top mantissa bits}
   function automatic logic [36:0] sqrt_entry(input logic [9:0] idx);
      longint av;
      longint x0;
      longint c;
      longint g;
      real    sc;
      real    s1;
      real    s2;
      real    ss;
      av = 64'sd512 + longint'(idx[8:0]);
      sc = idx[9] ? 1.0 : 2.0;
      s1 = rnd24($sqrt(real'(av) / 512.0 * sc));
      s2 = rnd24($sqrt(real'(av + 1) / 512.0 * sc));
      ss = rnd24(s1 + s2);
      x0 = mant24(ss / 2.0);
      c  = (x0 / 2 + div_q(idx[9] ? (av << 36) : (av << 37), x0)) & 64'sh7F_FFFF;
      g  = div_q(64'sd1 << 36, x0) & 64'sh7F_FFFF;
      return {c[22:0], g[13:0]};
   endfunction

   function automatic recip_rom_type build_recip();
      recip_rom_type rom;
      for (int i = 0; i < TableDepth; i++) rom[i] = recip_entry(10'(i));
      return rom;
   endfunction

   function automatic sqrt_rom_type build_sqrt();
      sqrt_rom_type rom;
      for (int i = 0; i < TableDepth; i++) rom[i] = sqrt_entry(10'(i));
      return rom;
   endfunction

endpackage

### rtl/single_float_arith_unit.sv
// each word moves through stage one, two and three, then into the result register
// throughput: one word per cycle; a stalled output freezes all stages
// reciprocal and square root tables are 1024-word read-only memories read in stage one
// reset clears the stage valid bits only; data registers hold whatever they held
module single_float_arith_unit import sfau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result
);

   logic        en;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]  op1_ff, op2_ff, op3_ff;
   logic [31:0] result_ff;
   logic [31:0] result_in;
   logic [31:0] add_res, mul_res, sqrt_res;

   // pipeline advances whenever the output stage is free or drained
   assign en        = !v4_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = v4_ff;
   assign rsp_result = result_ff;

   sfau_add u_add (
      .clock  (clock),
      .en     (en),
      .op     (req_operation),
      .a      (req_operand_a),
      .b      (req_operand_b),
      .result (add_res)
   );

   sfau_mdiv u_mdiv (
      .clock       (clock),
      .en          (en),
      .op          (req_operation),
      .a           (req_operand_a),
      .b           (req_operand_b),
      .mul_result  (mul_res),
      .sqrt_result (sqrt_res)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // operation code travels with the word
   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff    <= req_operation;
         op2_ff    <= op1_ff;
         op3_ff    <= op2_ff;
         result_ff <= result_in;
      end
   end

   // result select
   always_comb begin
      case (op3_ff)
         OP_ADD, OP_SUB: result_in = add_res;
         OP_MUL, OP_DIV: result_in = mul_res;
         OP_SQRT:        result_in = sqrt_res;
         default:        result_in = 32'd0;
      endcase
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff) |=> rsp_valid)
      else $error("word lost between stage three and output");

   a_unused_code_zero: assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff && op3_ff > OP_SQRT) |=> rsp_result == 32'd0)
      else $error("unused operation gave a nonzero word");

   a_root_positive: assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff && op3_ff == OP_SQRT) |=> !rsp_result[31])
      else $error("square root with sign set");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v1_ff) && $stable(v2_ff) && $stable(v3_ff) && $stable(op3_ff))
      else $error("pipeline moved during a stall");

endmodule

### rtl/sfau_add.sv
module sfau_add import sfau_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [2:0]  op,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] result
);

   // stage 1: order operands by magnitude, alignment distance, zero cases
   logic        bsign;
   logic        a_gt_b;
   logic        az, bz;
   logic [7:0]  diff_ab, diff_ba, d_raw;
   logic [4:0]  d_in;
   logic        ls_in, sub_in, spec_in;
   logic [7:0]  le_in;
   logic [23:0] lm_in, sm_in;
   logic [31:0] spec_val_in;

   logic        ls1_ff, sub1_ff, spec1_ff;
   logic [7:0]  le1_ff;
   logic [23:0] lm1_ff, sm1_ff;
   logic [4:0]  d1_ff;
   logic [31:0] spec_val1_ff;

   always_comb begin
      bsign   = b[31] ^ (op == OP_SUB);
      a_gt_b  = a[30:0] > b[30:0];
      az      = a[30:23] == 8'd0;
      bz      = b[30:23] == 8'd0;
      diff_ab = a[30:23] - b[30:23];
      diff_ba = b[30:23] - a[30:23];
      d_raw   = a_gt_b ? diff_ab : diff_ba;
      d_in    = (d_raw > 8'd24) ? 5'd24 : d_raw[4:0];
      ls_in   = a_gt_b ? a[31] : bsign;
      le_in   = a_gt_b ? a[30:23] : b[30:23];
      lm_in   = a_gt_b ? {1'b1, a[22:0]} : {1'b1, b[22:0]};
      sm_in   = a_gt_b ? {1'b1, b[22:0]} : {1'b1, a[22:0]};
      sub_in  = a[31] ^ bsign;
      spec_in = az || bz;
      if (az && bz) spec_val_in = {a[31] & bsign, 31'd0};
      else if (bz)  spec_val_in = a;
      else          spec_val_in = {bsign, b[30:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ls1_ff       <= ls_in;
         sub1_ff      <= sub_in;
         spec1_ff     <= spec_in;
         le1_ff       <= le_in;
         lm1_ff       <= lm_in;
         sm1_ff       <= sm_in;
         d1_ff        <= d_in;
         spec_val1_ff <= spec_val_in;
      end
   end

   // stage 2: align the smaller operand and add or subtract
   logic [23:0] sm_sh;
   logic [24:0] raw_in;
   logic        ls2_ff, spec2_ff;
   logic [7:0]  le2_ff;
   logic [24:0] raw2_ff;
   logic [31:0] spec_val2_ff;

   always_comb begin
      sm_sh  = sm1_ff >> d1_ff;
      raw_in = sub1_ff ? ({1'b0, lm1_ff} - {1'b0, sm_sh}) : ({1'b0, lm1_ff} + {1'b0, sm_sh});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ls2_ff       <= ls1_ff;
         spec2_ff     <= spec1_ff;
         le2_ff       <= le1_ff;
         raw2_ff      <= raw_in;
         spec_val2_ff <= spec_val1_ff;
      end
   end

   // stage 3: leading zero count and normalise
   logic [4:0]  sh;
   logic        found;
   logic [23:0] norm;
   logic [22:0] mant_in;
   logic [9:0]  e_in;
   logic        zero_in;
   logic        ls3_ff, spec3_ff, zero3_ff;
   logic [22:0] mant3_ff;
   logic [9:0]  e3_ff;
   logic [31:0] spec_val3_ff;

   always_comb begin
      sh    = 5'd0;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && raw2_ff[i]) begin
            sh    = 5'(23 - i);
            found = 1'b1;
         end
      end
      norm    = raw2_ff[23:0] << sh;
      zero_in = raw2_ff == 25'd0;
      if (raw2_ff[24]) begin
         mant_in = raw2_ff[23:1];
         e_in    = {2'b00, le2_ff} + 10'd1;
      end else begin
         mant_in = norm[22:0];
         e_in    = {2'b00, le2_ff} - {5'd0, sh};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ls3_ff       <= ls2_ff;
         spec3_ff     <= spec2_ff;
         zero3_ff     <= zero_in;
         mant3_ff     <= mant_in;
         e3_ff        <= e_in;
         spec_val3_ff <= spec_val2_ff;
      end
   end

   // pack with flush to zero and overflow to infinity
   always_comb begin
      if (spec3_ff)                       result = spec_val3_ff;
      else if (zero3_ff)                  result = 32'd0;
      else if ($signed(e3_ff) <= 10'sd0)  result = {ls3_ff, 31'd0};
      else if ($signed(e3_ff) >= 10'sd255) result = {ls3_ff, 8'hff, 23'd0};
      else                                result = {ls3_ff, e3_ff[7:0], mant3_ff};
   end

endmodule

### rtl/sfau_mdiv.sv
module sfau_mdiv import sfau_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [2:0]  op,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] mul_result,
   output logic [31:0] sqrt_result
);

   localparam recip_rom_type RecipRom = build_recip();
   localparam sqrt_rom_type  SqrtRom  = build_sqrt();

   // stage 1: exponents, zero cases and table reads
   logic        is_div;
   logic        az, bz;
   logic [9:0]  eyp_in;
   logic [8:0]  sq_sum;

   logic        div1_ff, sy1_ff, zres1_ff, inf1_ff, e01_ff, sqz1_ff;
   logic [9:0]  eyp1_ff;
   logic [22:0] ma1_ff, mb1_ff;
   logic [12:0] lowb1_ff;
   logic [13:0] lowa1_ff;
   logic [7:0]  sqe1_ff;
   logic [35:0] rrom1_ff;
   logic [36:0] srom1_ff;

   always_comb begin
      is_div = op == OP_DIV;
      az     = a[30:23] == 8'd0;
      bz     = b[30:23] == 8'd0;
      eyp_in = is_div ? ({2'b00, a[30:23]} + 10'd126 - {2'b00, b[30:23]})
                      : ({2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127);
      sq_sum = {1'b0, a[30:23]} + 9'd126 + {8'd0, a[23]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div1_ff  <= is_div;
         sy1_ff   <= a[31] ^ b[31];
         zres1_ff <= is_div ? az : (az || bz);
         inf1_ff  <= is_div && !az && bz;
         e01_ff   <= a[23];
         sqz1_ff  <= a[31] || az;
         eyp1_ff  <= eyp_in;
         ma1_ff   <= a[22:0];
         mb1_ff   <= b[22:0];
         lowb1_ff <= b[12:0];
         lowa1_ff <= a[13:0];
         sqe1_ff  <= sq_sum[8:1];
         rrom1_ff <= RecipRom[b[22:13]];
         srom1_ff <= SqrtRom[{a[23], a[22:14]}];
      end
   end

   // stage 2: linear correction of the table values
   logic [25:0] rprod;
   logic [22:0] rmant;
   logic [27:0] sprod;
   logic [27:0] sprod_sh;
   logic [23:0] sq_m_in;

   logic        sy2_ff, zres2_ff, inf2_ff, sqz2_ff;
   logic [9:0]  eyp2_ff;
   logic [22:0] ma2_ff, mb2_ff;
   logic [7:0]  sqe2_ff;
   logic [23:0] sqm2_ff;

   always_comb begin
      rprod    = lowb1_ff * rrom1_ff[12:0];
      rmant    = rrom1_ff[35:13] - {9'd0, rprod[25:12]};
      sprod    = lowa1_ff * srom1_ff[13:0];
      sprod_sh = e01_ff ? (sprod >> 14) : (sprod >> 13);
      sq_m_in  = {1'b0, srom1_ff[36:14]} + sprod_sh[23:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sy2_ff   <= sy1_ff;
         zres2_ff <= zres1_ff;
         inf2_ff  <= inf1_ff;
         sqz2_ff  <= sqz1_ff;
         eyp2_ff  <= eyp1_ff;
         ma2_ff   <= ma1_ff;
         mb2_ff   <= div1_ff ? rmant : mb1_ff;
         sqe2_ff  <= sqe1_ff;
         sqm2_ff  <= sq_m_in;
      end
   end

   // stage 3: significand product
   logic        sy3_ff, zres3_ff, inf3_ff, sqz3_ff;
   logic [9:0]  eyp3_ff;
   logic [47:0] prod3_ff;
   logic [7:0]  sqe3_ff;
   logic [23:0] sqm3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sy3_ff   <= sy2_ff;
         zres3_ff <= zres2_ff;
         inf3_ff  <= inf2_ff;
         sqz3_ff  <= sqz2_ff;
         eyp3_ff  <= eyp2_ff;
         prod3_ff <= {1'b1, ma2_ff} * {1'b1, mb2_ff};
         sqe3_ff  <= sqe2_ff;
         sqm3_ff  <= sqm2_ff;
      end
   end

   // pack: product normalise, flush and overflow; root mantissa carry into exponent
   logic [9:0]  e_fin;
   logic [22:0] mant_fin;

   always_comb begin
      e_fin    = eyp3_ff + {9'd0, prod3_ff[47]};
      mant_fin = prod3_ff[47] ? prod3_ff[46:24] : prod3_ff[45:23];
      if (zres3_ff)                        mul_result = {sy3_ff, 31'd0};
      else if (inf3_ff)                    mul_result = {sy3_ff, 8'hff, 23'd0};
      else if ($signed(e_fin) >= 10'sd255) mul_result = {sy3_ff, 8'hff, 23'd0};
      else if ($signed(e_fin) <= 10'sd0)   mul_result = {sy3_ff, 31'd0};
      else                                 mul_result = {sy3_ff, e_fin[7:0], mant_fin};
      if (sqz3_ff) sqrt_result = 32'd0;
      else sqrt_result = {1'b0, sqe3_ff[7:1], sqe3_ff[0] | sqm3_ff[23], sqm3_ff[22:0]};
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import sfau_pkg::*;

   localparam int NumRandom = 1400;
   localparam int Stall_Limit = 5000;
   localparam int DrainCycles = 12;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result;

   // one directed row: operation, operands, and a typed-in result where obvious
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      logic        typed;
      logic [31:0] res;
   } dir_row_type;

   localparam int NumDirected = 24;
   dir_row_type dir_tab [NumDirected];
   logic [31:0] pending_results [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          calm = 0;

   single_float_arith_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result(rsp_result)
   );

   // clock
   initial clock = 0;
   always #5 clock = ~clock;

   // ---------------- predictor ----------------

   // round a 25-bit sum to a 24-bit significand, ties to even
   function automatic logic [63:0] round_sum(input logic [63:0] s);
      logic [63:0] q;
      q = s >> 1;
      if (s[0] && q[0]) q = q + 1;
      if (q == 64'h100_0000) q = 64'h80_0000;
      return q;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n, output logic [63:0] rem);
      logic [63:0] s;
      logic [63:0] bt;
      s = 0;
      bt = 64'h1 << 62;
      rem = n;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         if (rem >= s + bt) begin
            rem = rem - (s + bt);
            s = (s >> 1) + bt;
         end else begin
            s = s >> 1;
         end
         bt = bt >> 2;
      end
      return s;
   endfunction

   function automatic logic [31:0] sum_word(input logic [31:0] a, input logic [31:0] b);
      int unsigned as_, bs_, ls, ss, mant;
      int ae, be, le, se, d, sh, e, lm, sm, am, bm, raw;
      as_ = 32'(a[31]);
      bs_ = 32'(b[31]);
      ae = int'(a[30:23]);
      be = int'(b[30:23]);
      am = {9'd1, a[22:0]};
      bm = {9'd1, b[22:0]};
      sh = 0;
      if (ae == 0 && be == 0) return {as_[0] & bs_[0], 31'd0};
      if (be == 0) return a;
      if (ae == 0) return b;
      if (ae > be || (ae == be && am > bm)) begin
         ls = as_; le = ae; lm = am; ss = bs_; se = be; sm = bm;
      end else begin
         ls = bs_; le = be; lm = bm; ss = as_; se = ae; sm = am;
      end
      d = le - se;
      if (d > 24) d = 24;
      sm = sm >>> d;
      raw = (ss != ls) ? lm - sm : lm + sm;
      if (raw == 0) return 32'd0;
      if (raw[24]) begin
         mant = (raw >> 1) & 32'h7f_ffff;
         e = le + 1;
      end else begin
         while (((raw << sh) & 32'h80_0000) == 0) sh++;
         mant = (raw << sh) & 32'h7f_ffff;
         e = le - sh;
      end
      if (e <= 0) return {ls[0], 31'd0};
      if (e >= 255) return {ls[0], 8'hff, 23'd0};
      return {ls[0], e[7:0], mant[22:0]};
   endfunction

   // truncated significand product, exponent given before normalising
   function automatic logic [31:0] prod_word(input logic sy, input int ey,
                                             input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      logic [22:0] mant;
      int e;
      p = {40'd0, 1'b1, a[22:0]} * {40'd0, 1'b1, b[22:0]};
      e = p[47] ? ey + 1 : ey;
      mant = p[47] ? p[46:24] : p[45:23];
      if (e >= 255) return {sy, 8'hff, 23'd0};
      if (e <= 0) return {sy, 31'd0};
      return {sy, e[7:0], mant};
   endfunction

   function automatic logic [22:0] recip_mantissa(input logic [31:0] b);
      logic [63:0] k, kl, n1, n2, q, rm, x0, c, g;
      int kk;
      kl = 64'(b[22:13]);
      k = 1024 + kl;
      n1 = 0;
      n2 = 0;
      // correctly rounded 1024/k and 1024/(k+1), in units of 2^-24
      for (kk = 0; kk < 2; kk++) begin
         q = (64'h1 << 34) / (k + kk);
         rm = (64'h1 << 34) % (k + kk);
         if (2 * rm > k + kk || (2 * rm == k + kk && q[0])) q = q + 1;
         if (kk == 0) n1 = q; else n2 = q;
      end
      x0 = round_sum(n1 + n2);
      c = (2 * x0 - ((x0 * x0 * k) >> 34)) & 64'hffff_ffff;
      if (kl == 'h2 || kl == 'h3 || kl == 'h6 || kl == 'h7 || kl == 'h9 ||
          kl == 'ha || kl == 'he || kl == 'h19 || kl == 'h20 || kl == 'h22)
         c = c + 1;
      c = c & 64'h7f_ffff;
      g = ((x0 * x0) >> 35) & 64'h7f_ffff;
      return 23'(c - ((64'(b[12:0]) * g) >> 12));
   endfunction

   function automatic logic [31:0] root_word(input logic [31:0] a);
      logic [63:0] av, x0, c, g, r, rm, t1, t2, nn;
      logic [31:0] m, e;
      logic e0;
      int kk;
      e0 = a[23];
      t1 = 0;
      t2 = 0;
      if (a[31]) return 32'd0;
      if (a[30:23] == 0) return 32'd0;
      av = {55'd1, a[22:14]};
      // correctly rounded square roots of the segment ends, in units of 2^-23
      for (kk = 0; kk < 2; kk++) begin
         nn = (av + kk) << (e0 ? 37 : 38);
         r = int_sqrt(nn, rm);
         if (rm > r) r = r + 1;
         if (kk == 0) t1 = r; else t2 = r;
      end
      x0 = round_sum(t1 + t2);
      c = (x0 / 2 + ((av << (e0 ? 36 : 37)) / x0)) & 64'h7f_ffff;
      g = ((64'h1 << 36) / x0) & 64'h7f_ffff;
      m = 32'(c + ((g * 64'(a[13:0])) >> (e0 ? 14 : 13)));
      e = e0 ? (32'(a[30:23]) + 127) / 2 : (32'(a[30:23]) + 126) / 2;
      return (e << 23) | m;
   endfunction

   function automatic logic [31:0] fpu_result(input logic [2:0] op, input logic [31:0] a,
                                              input logic [31:0] b);
      int ae, be;
      ae = int'(a[30:23]);
      be = int'(b[30:23]);
      case (op)
         OP_ADD:  return sum_word(a, b);
         OP_SUB:  return sum_word(a, b ^ 32'h8000_0000);
         OP_MUL: begin
            if (ae == 0 || be == 0) return {a[31] ^ b[31], 31'd0};
            return prod_word(a[31] ^ b[31], ae + be - 127, a, b);
         end
         OP_DIV: begin
            if (ae == 0) return {a[31] ^ b[31], 31'd0};
            if (be == 0) return {a[31] ^ b[31], 8'hff, 23'd0};
            return prod_word(a[31] ^ b[31], ae + 126 - be, a,
                             {b[31:23], recip_mantissa(b)});
         end
         OP_SQRT: return root_word(a);
         default: return 32'd0;
      endcase
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: v[30:23] = 8'($urandom_range(100, 154));
         2: begin
            case ($urandom_range(0, 3))
               0: v[30:23] = 8'd0;
               1: v[30:23] = 8'd1;
               2: v[30:23] = 8'd254;
               default: v[30:23] = 8'd255;
            endcase
         end
         default: v[30:23] = 8'($urandom_range(60, 200));
      endcase
      return v;
   endfunction

   function automatic logic [31:0] partner_operand(input logic [31:0] a);
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = a;
         1: v = a ^ 32'h8000_0000;
         2: v = a ^ (32'h1 << $urandom_range(0, 22));
         3: begin
            v = $urandom;
            v[30:23] = a[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
         end
         default: v = rand_operand();
      endcase
      return v;
   endfunction

   // send one word and file its expected result once accepted
   task automatic send_word(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b,
                            input logic typed, input logic [31:0] res);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(typed ? res : fpu_result(op, a, b));
   endtask

   // ---------------- directed table ----------------
   initial begin
      dir_tab[0]  = '{OP_ADD,  32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h4000_0000};
      dir_tab[1]  = '{OP_ADD,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000};
      dir_tab[2]  = '{OP_ADD,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
      dir_tab[3]  = '{OP_SUB,  32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h0000_0000};
      dir_tab[4]  = '{OP_ADD,  32'hc120_0000, 32'h0000_0000, 1'b1, 32'hc120_0000};
      dir_tab[5]  = '{OP_MUL,  32'h8000_0000, 32'h3f80_0000, 1'b1, 32'h8000_0000};
      dir_tab[6]  = '{OP_DIV,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
      dir_tab[7]  = '{OP_DIV,  32'h3f80_0000, 32'h0000_0000, 1'b1, 32'h7f80_0000};
      dir_tab[8]  = '{OP_DIV,  32'hbf80_0000, 32'h0000_0001, 1'b1, 32'hff80_0000};
      dir_tab[9]  = '{OP_SQRT, 32'hbf80_0000, 32'h1234_5678, 1'b1, 32'h0000_0000};
      dir_tab[10] = '{OP_SQRT, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
      dir_tab[11] = '{OP_SQRT, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000};
      dir_tab[12] = '{3'd5,    32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h0000_0000};
      dir_tab[13] = '{3'd6,    32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0000};
      dir_tab[14] = '{3'd7,    32'h7f7f_ffff, 32'h0080_0000, 1'b1, 32'h0000_0000};
      // checked against the predictor
      dir_tab[15] = '{OP_MUL,  32'h7f7f_ffff, 32'h7f7f_ffff, 1'b0, 32'h0};
      dir_tab[16] = '{OP_MUL,  32'h0080_0000, 32'h8080_0000, 1'b0, 32'h0};
      dir_tab[17] = '{OP_ADD,  32'h7f7f_ffff, 32'h7f7f_ffff, 1'b0, 32'h0};
      dir_tab[18] = '{OP_SUB,  32'h3f80_0001, 32'h3f80_0000, 1'b0, 32'h0};
      dir_tab[19] = '{OP_ADD,  32'h7f80_0000, 32'h3f80_0000, 1'b0, 32'h0};
      dir_tab[20] = '{OP_DIV,  32'h3f80_0000, 32'h4040_0000, 1'b0, 32'h0};
      dir_tab[21] = '{OP_SQRT, 32'h4080_0000, 32'h0000_0000, 1'b0, 32'h0};
      dir_tab[22] = '{OP_SQRT, 32'h7f7f_ffff, 32'h0000_0000, 1'b0, 32'h0};
      dir_tab[23] = '{OP_DIV,  32'h0080_0000, 32'h7fff_ffff, 1'b0, 32'h0};
   end

   // ---------------- sender ----------------
   initial begin
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = 3'd0;
      req_operand_a = 32'd0;
      req_operand_b = 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_word(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].res);

      for (int n = 0; n < NumRandom; n++) begin
         // every third stretch of 200 words runs without idling
         if (n % 200 == 0) calm = (n / 200) % 3 == 1;
         // hold off until the pipe is empty
         if (n == 700) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
         a = rand_operand();
         b = partner_operand(a);
         send_word(op, a, b, 1'b0, 32'h0);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("** single_float_arith_unit: PASSED **");
      else
         $display("** single_float_arith_unit: FAILED **");
      $finish;
   end

   // ---------------- receiver stalls ----------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- result check ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with none expected: %h", rsp_result);
            fail_count++;
         end else begin
            if (rsp_result !== pending_results[0]) begin
               $error("result: expected %h, actual %h", pending_results[0], rsp_result);
               fail_count++;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= Stall_Limit) begin
         $display("** single_float_arith_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
